// ===== hdl/bll_pkg.sv =====
// ----------------------------------------------------------------------------
// bll_pkg
// Shared widths, codes and defaults for the bounded letter list.
// ----------------------------------------------------------------------------
package bll_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int LETTER_W = 8;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 8;

    localparam logic [LETTER_W-1:0] LETTER_LOW  = 8'd65;  // 'A'
    localparam logic [LETTER_W-1:0] LETTER_HIGH = 8'd90;  // 'Z'

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd2;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd4;
    localparam logic [OP_W-1:0] OP_PRINT  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

endpackage

// ===== hdl/bll_item_if.sv =====
// ----------------------------------------------------------------------------
// bll_item_if
// Command channel: one operation and its letter per beat.
// ----------------------------------------------------------------------------
interface bll_item_if;
    logic                          valid;
    logic                          ready;
    logic [bll_pkg::OP_W-1:0]      operation;
    logic [bll_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output operation, output letter, input ready);
    modport sink   (input valid, input operation, input letter, output ready);
endinterface

// ===== hdl/bll_result_if.sv =====
// ----------------------------------------------------------------------------
// bll_result_if
// Result channel: status, value and last flag per beat.
// ----------------------------------------------------------------------------
interface bll_result_if;
    logic                          valid;
    logic                          ready;
    logic [bll_pkg::STATUS_W-1:0]  status;
    logic [bll_pkg::VALUE_W-1:0]   value;
    logic                          last;

    modport source (output valid, output status, output value, output last, input ready);
    modport sink   (input valid, input status, input value, input last, output ready);
endinterface

// ===== hdl/bounded_letter_list.sv =====
// ----------------------------------------------------------------------------
// bounded_letter_list
// Ordered list of up to DEPTH capital letters, newest first, with push,
// remove, length, head, tail and print operations.
// ----------------------------------------------------------------------------
// One command is taken at a time; item.ready is high only while the sequencer
// is idle, but a command may be taken while the previous result still waits
// in the output register. Everything runs through one single-port-read,
// single-port-write memory with a registered read, so the walk is one entry
// per cycle, save that print waits while the result side stalls. Push and
// length answer from the idle state, head and tail go through a read state,
// remove searches from the front, then closes the gap one entry per cycle,
// and print walks front to back. An empty list answers every command with no read.
// The memory needs no clearing pass: only entries below the count are read.
// ----------------------------------------------------------------------------
module bounded_letter_list #(
    parameter int DEPTH = bll_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    bll_item_if.sink            item,
    bll_result_if.source        result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Storage is kept back to front: physical entry 0 is the tail and entry
    // count-1 is the front, so a push is a plain append.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,  // head/tail read data lands
        S_SCAN  = 6'b000100,  // remove: search from the front
        S_SHIFT = 6'b001000,  // remove: close the gap
        S_PRINT = 6'b010000,  // walk front to back, one beat per entry
        S_EMIT  = 6'b100000   // hand the single result to the output register
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [bll_pkg::LETTER_W-1:0]  letter_reg, letter_next;
    logic [bll_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [bll_pkg::VALUE_W-1:0]   res_value_reg, res_value_next;

    logic                          out_valid_reg, out_valid_next;
    logic [bll_pkg::STATUS_W-1:0]  out_status_reg;
    logic [bll_pkg::VALUE_W-1:0]   out_value_reg;
    logic                          out_last_reg;

    // memory
    logic [bll_pkg::LETTER_W-1:0]  mem [DEPTH];
    logic [bll_pkg::LETTER_W-1:0]  rd_data_reg;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [bll_pkg::LETTER_W-1:0]  wr_data;

    // output register load
    logic                          out_free;
    logic                          out_load;
    logic [bll_pkg::STATUS_W-1:0]  ld_status;
    logic [bll_pkg::VALUE_W-1:0]   ld_value;
    logic                          ld_last;

    logic [CW-1:0]                 cnt_m1;
    logic [AW-1:0]                 top_addr;
    logic                          in_letter_ok;
    logic                          empty;

    assign cnt_m1       = count_reg - CW'(1);
    assign top_addr     = cnt_m1[AW-1:0];
    assign empty        = (count_reg == '0);
    assign in_letter_ok = (item.letter >= bll_pkg::LETTER_LOW) &&
                          (item.letter <= bll_pkg::LETTER_HIGH);
    assign out_free     = !out_valid_reg || result.ready;

    assign item.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.value  = out_value_reg;
    assign result.last   = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        letter_next     = letter_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data_reg;
        out_load        = 1'b0;
        ld_status       = bll_pkg::ST_OK;
        ld_value        = rd_data_reg;
        ld_last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    letter_next     = item.letter;
                    res_status_next = bll_pkg::ST_INVALID;
                    res_value_next  = '0;
                    state_next      = S_EMIT;
                    unique case (item.operation)
                        bll_pkg::OP_PUSH:
                        begin
                            // letter check wins over the full check
                            if (!in_letter_ok)
                                res_status_next = bll_pkg::ST_INVALID;
                            else if (count_reg == CW'(DEPTH))
                                res_status_next = bll_pkg::ST_FULL;
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = count_reg[AW-1:0];
                                wr_data         = item.letter;
                                count_next      = count_reg + CW'(1);
                                res_status_next = bll_pkg::ST_OK;
                            end
                        end
                        bll_pkg::OP_REMOVE:
                        begin
                            if (in_letter_ok && !empty)
                            begin
                                idx_next   = top_addr;
                                rd_addr    = top_addr;
                                state_next = S_SCAN;
                            end
                        end
                        bll_pkg::OP_LENGTH:
                        begin
                            if (!empty)
                            begin
                                res_status_next = bll_pkg::ST_OK;
                                res_value_next  = bll_pkg::VALUE_W'(count_reg);
                            end
                        end
                        bll_pkg::OP_HEAD:
                        begin
                            if (!empty)
                            begin
                                rd_addr    = top_addr;
                                state_next = S_READ;
                            end
                        end
                        bll_pkg::OP_TAIL:
                        begin
                            if (!empty)
                            begin
                                rd_addr    = '0;
                                state_next = S_READ;
                            end
                        end
                        bll_pkg::OP_PRINT:
                        begin
                            if (empty)
                                res_status_next = bll_pkg::ST_EMPTY;
                            else
                            begin
                                idx_next   = top_addr;
                                rd_addr    = top_addr;
                                state_next = S_PRINT;
                            end
                        end
                        default:
                        begin
                            res_status_next = bll_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_status_next = bll_pkg::ST_OK;
                res_value_next  = rd_data_reg;
                state_next      = S_EMIT;
            end

            S_SCAN:
            begin
                // rd_data_reg holds entry idx_reg
                if (rd_data_reg == letter_reg)
                begin
                    if (CW'(idx_reg) == cnt_m1)
                    begin
                        // match at the front: nothing to move
                        count_next      = cnt_m1;
                        res_status_next = bll_pkg::ST_OK;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        rd_addr    = idx_reg + AW'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_status_next = bll_pkg::ST_INVALID;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    rd_addr  = idx_reg - AW'(1);
                end
            end

            S_SHIFT:
            begin
                // rd_data_reg holds entry idx_reg+1; move it down one place
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (CW'(idx_reg) + CW'(1) == cnt_m1)
                begin
                    count_next      = cnt_m1;
                    res_status_next = bll_pkg::ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = idx_reg + AW'(2);
                end
            end

            S_PRINT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    ld_status = bll_pkg::ST_OK;
                    ld_value  = rd_data_reg;
                    ld_last   = (idx_reg == '0);
                    if (idx_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        rd_addr  = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    // re-read the same entry so the data holds over the stall
                    rd_addr = idx_reg;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = res_status_reg;
                    ld_value   = res_value_reg;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        letter_reg     <= letter_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_value_reg  <= ld_value;
            out_last_reg   <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== hdl/bll_checker.sv =====
// ----------------------------------------------------------------------------
// bll_checker
// Port-level checks on the bounded letter list, bound to the top level.
// ----------------------------------------------------------------------------
module bll_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [bll_pkg::STATUS_W-1:0]  result_status,
    input  logic [bll_pkg::VALUE_W-1:0]   result_value,
    input  logic                          result_last
);

    logic       item_beat;
    logic       last_beat;
    logic [1:0] open_reg, open_next;

    assign item_beat = item_valid && item_ready;
    assign last_beat = result_valid && result_ready && result_last;

    // commands taken whose last beat has not gone out yet
    always_comb
    begin
        open_next = open_reg;
        if (item_beat && !last_beat)
            open_next = open_reg + 2'd1;
        else if (!item_beat && last_beat && open_reg != 2'd0)
            open_next = open_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 2'd0;
        else
            open_reg <= open_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_status) && $stable(result_value) &&
            $stable(result_last))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |=> !item_ready)
        else $error("command taken while the previous one is still at work");

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> open_reg != 2'd0)
        else $error("result beat without a command behind it");

    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status != bll_pkg::ST_OK |->
            result_last && result_value == '0)
        else $error("non-ok status must be a single last beat with value 0");

endmodule

bind bounded_letter_list bll_checker u_bll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_status (result.status),
    .result_value  (result.value),
    .result_last   (result.last)
);
